/* hw/rtl/uv_sphere_tessellator_assert.svh */
// Assertion macros for the UV sphere tessellator checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef UV_SPHERE_TESSELLATOR_ASSERT_SVH
`define UV_SPHERE_TESSELLATOR_ASSERT_SVH

// Implication checked outside reset.
`define UVS_ASSERT_RUN(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvs check failed");

// Implication checked in the next cycle, during reset too.
`define UVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("uvs reset check failed");

`endif

/* hw/rtl/uvs_pkg.sv */
// Shared types and constants for the UV sphere tessellator.
// No dependencies.
package uvs_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam logic [17:0] CORDIC_START = 18'd19898;
  localparam int SIN_LIMIT = 32767;
  localparam int POS_LIMIT = 65535;
  localparam logic [2:0] LAST_VERTEX = 3'd5;

  // Corner offsets per vertex number, bit k for vertex k.
  localparam logic [5:0] CORNER_DI = 6'b001110;
  localparam logic [5:0] CORNER_DJ = 6'b101010;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_SLICE  = 2'd1;
  localparam logic [1:0] REG_STACK  = 2'd2;

  typedef struct packed {
    logic [7:0] stack_index;
    logic [7:0] slice_index;
  } cell_t;

  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] slice_step;
    logic [15:0] stack_step;
  } cfg_t;

  // atan(2^-k) in 1/65536 turn
  function automatic logic [15:0] atan_turn(input logic [3:0] k);
    logic [15:0] v;
    unique case (k)
      4'd0:  v = 16'd8192;
      4'd1:  v = 16'd4836;
      4'd2:  v = 16'd2555;
      4'd3:  v = 16'd1297;
      4'd4:  v = 16'd651;
      4'd5:  v = 16'd326;
      4'd6:  v = 16'd163;
      4'd7:  v = 16'd81;
      4'd8:  v = 16'd41;
      4'd9:  v = 16'd20;
      4'd10: v = 16'd10;
      4'd11: v = 16'd5;
      4'd12: v = 16'd3;
      4'd13: v = 16'd1;
      4'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/uvs_front.sv */
// Front end: takes cell requests, masks indices, queues them (two entries).
// Depends on uvs_pkg.
module uvs_front import uvs_pkg::*; #(
  parameter int IW = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  output logic        cell_valid,
  output cell_t       cell_req,
  input  logic        cell_pop
);

  cell_t       q_r [0:1];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  cell_t       masked;
  logic [7:0]  mask;

  assign mask = 8'((9'd1 << IW) - 9'd1);
  assign masked.slice_index = in_tdata[7:0] & mask;
  assign masked.stack_index = in_tdata[15:8] & mask;

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign cell_valid = (count_r != 2'd0);
  assign cell_req   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= masked;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cell_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(cell_pop);
    end
  end

endmodule

/* hw/rtl/uvs_back.sv */
// Back end: walks the six corners of a cell, CORDIC sin/cos pipeline,
// scaling multipliers and the output register. Depends on uvs_pkg.
module uvs_back import uvs_pkg::*; #(
  parameter int IW = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        cell_valid,
  input  cell_t       cell_req,
  output logic        cell_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tlast
);

  localparam int NS = CORDIC_STAGES;

  logic        adv;
  logic [2:0]  vtx_r;
  logic [IW:0] p, q;
  logic [IW+16:0] prod_a, prod_b;
  logic [15:0] ph_a, ph_b;

  // CORDIC pipeline, index 0 is the folded start
  logic               v_r    [0:NS];
  logic               last_r [0:NS];
  logic               fa_r   [0:NS];
  logic               fb_r   [0:NS];
  logic signed [17:0] ax_r [0:NS], ay_r [0:NS], az_r [0:NS];
  logic signed [17:0] bx_r [0:NS], by_r [0:NS], bz_r [0:NS];

  logic               vf_r, lf_r, vm1_r, lm1_r, vm2_r, lm2_r;
  logic signed [15:0] sa_r, ca_r, sb_r, cb_r;
  logic signed [15:0] sa2_r, ca2_r;
  logic signed [32:0] rsb_r, ry_r, ry2_r;
  logic signed [48:0] vx_r, vz_r;
  logic               out_valid_r, out_last_r;
  logic signed [16:0] ox_r, oy_r, oz_r;

  function automatic logic signed [15:0] fin(input logic signed [17:0] v,
                                             input logic flip);
    logic signed [17:0] t;
    t = flip ? -v : v;
    if (t > 18'sd32767) return 16'sd32767;
    if (t < -18'sd32767) return -16'sd32767;
    return t[15:0];
  endfunction

  function automatic logic signed [16:0] pos_clamp(input logic signed [19:0] v);
    if (v > 20'sd65535) return 17'sd65535;
    if (v < -20'sd65535) return -17'sd65535;
    return v[16:0];
  endfunction

  assign adv      = !out_valid_r || out_tready;
  assign cell_pop = adv && cell_valid && (vtx_r == LAST_VERTEX);

  assign p = {1'b0, cell_req.slice_index[IW-1:0]} + (IW+1)'(CORNER_DI[vtx_r]);
  assign q = {1'b0, cell_req.stack_index[IW-1:0]} + (IW+1)'(CORNER_DJ[vtx_r]);
  assign prod_a = {16'd0, p} * {{(IW+1){1'b0}}, cfg.slice_step};
  assign prod_b = {16'd0, q} * {{(IW+1){1'b0}}, cfg.stack_step};
  assign ph_a = prod_a[15:0];
  assign ph_b = prod_b[15:0];

  logic signed [19:0] rx, ryy, rz;
  logic signed [48:0] tx, tz;
  logic signed [32:0] ty;
  assign tx  = vx_r + 49'sd536870912;
  assign tz  = vz_r + 49'sd536870912;
  assign ty  = ry2_r + 33'sd16384;
  assign rx  = 20'(tx >>> 30);
  assign rz  = 20'(tz >>> 30);
  assign ryy = 20'(ty >>> 15);

  always_ff @(posedge clk) begin
    if (adv) begin
      // fold into a quarter turn either side of zero
      fa_r[0] <= ph_a[15] ^ ph_a[14];
      fb_r[0] <= ph_b[15] ^ ph_b[14];
      az_r[0] <= 18'(signed'({ph_a[15] ^ ph_a[14] ^ ph_a[15] ? 1'b1 : 1'b0, ph_a[14:0]}));
      bz_r[0] <= 18'(signed'({ph_b[15] ^ ph_b[14] ^ ph_b[15] ? 1'b1 : 1'b0, ph_b[14:0]}));
      ax_r[0] <= CORDIC_START;
      ay_r[0] <= 18'sd0;
      bx_r[0] <= CORDIC_START;
      by_r[0] <= 18'sd0;
      last_r[0] <= (vtx_r == LAST_VERTEX);
      for (int k = 0; k < NS; k++) begin
        last_r[k+1] <= last_r[k];
        fa_r[k+1] <= fa_r[k];
        fb_r[k+1] <= fb_r[k];
        if (!az_r[k][17]) begin
          ax_r[k+1] <= ax_r[k] - (ay_r[k] >>> k);
          ay_r[k+1] <= ay_r[k] + (ax_r[k] >>> k);
          az_r[k+1] <= az_r[k] - 18'(atan_turn(4'(k)));
        end else begin
          ax_r[k+1] <= ax_r[k] + (ay_r[k] >>> k);
          ay_r[k+1] <= ay_r[k] - (ax_r[k] >>> k);
          az_r[k+1] <= az_r[k] + 18'(atan_turn(4'(k)));
        end
        if (!bz_r[k][17]) begin
          bx_r[k+1] <= bx_r[k] - (by_r[k] >>> k);
          by_r[k+1] <= by_r[k] + (bx_r[k] >>> k);
          bz_r[k+1] <= bz_r[k] - 18'(atan_turn(4'(k)));
        end else begin
          bx_r[k+1] <= bx_r[k] + (by_r[k] >>> k);
          by_r[k+1] <= by_r[k] - (bx_r[k] >>> k);
          bz_r[k+1] <= bz_r[k] + 18'(atan_turn(4'(k)));
        end
      end
      lf_r <= last_r[NS];
      sa_r <= fin(ay_r[NS], fa_r[NS]);
      ca_r <= fin(ax_r[NS], fa_r[NS]);
      sb_r <= fin(by_r[NS], fb_r[NS]);
      cb_r <= fin(bx_r[NS], fb_r[NS]);
      lm1_r <= lf_r;
      rsb_r <= signed'({1'b0, cfg.radius}) * sb_r;
      ry_r  <= signed'({1'b0, cfg.radius}) * cb_r;
      sa2_r <= sa_r;
      ca2_r <= ca_r;
      lm2_r <= lm1_r;
      vx_r  <= rsb_r * sa2_r;
      vz_r  <= rsb_r * ca2_r;
      ry2_r <= ry_r;
      out_last_r <= lm2_r;
      ox_r <= pos_clamp(rx);
      oy_r <= pos_clamp(ryy);
      oz_r <= pos_clamp(rz);
    end
    if (!rst_n) begin
      vtx_r <= 3'd0;
      for (int k = 0; k <= NS; k++) v_r[k] <= 1'b0;
      vf_r <= 1'b0;
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (cell_valid) vtx_r <= (vtx_r == LAST_VERTEX) ? 3'd0 : vtx_r + 3'd1;
      v_r[0] <= cell_valid;
      for (int k = 0; k < NS; k++) v_r[k+1] <= v_r[k];
      vf_r <= v_r[NS];
      vm1_r <= vf_r;
      vm2_r <= vm1_r;
      out_valid_r <= vm2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, oz_r, oy_r, ox_r};

endmodule

/* hw/rtl/uv_sphere_tessellator.sv */
// From an accepted cell to its first vertex: corner issue, 16 CORDIC stages,
// sin/cos finish, two multiply stages, output register. Throughput: one vertex
// per cycle unless the output stalls, six vertices per cell on the single result
// channel. The pipeline stalls as a whole when the output waits.
// Reset (rst_n, synchronous): queue and pipeline emptied, radius 256, steps 4096.
module uv_sphere_tessellator import uvs_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // slice_index[7:0], stack_index[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // pos_x[16:0], pos_y[33:17], pos_z[50:34], zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW = (INDEX_BITS < 8) ? INDEX_BITS : 8;

  cfg_t  cfg_r;
  logic  cell_valid, cell_pop, wr_en;
  cell_t cell_req;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius     <= 16'd256;
      cfg_r.slice_step <= 16'd4096;
      cfg_r.stack_step <= 16'd4096;
    end else if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_RADIUS: cfg_r.radius     <= cfg_pwdata[15:0];
        REG_SLICE:  cfg_r.slice_step <= cfg_pwdata[15:0];
        REG_STACK:  cfg_r.stack_step <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_RADIUS: cfg_prdata = {16'd0, cfg_r.radius};
      REG_SLICE:  cfg_prdata = {16'd0, cfg_r.slice_step};
      REG_STACK:  cfg_prdata = {16'd0, cfg_r.stack_step};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  uvs_front #(.IW(IW)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cell_valid, .cell_req, .cell_pop
  );

  uvs_back #(.IW(IW)) u_back (
    .clk, .rst_n, .cfg(cfg_r), .cell_valid, .cell_req, .cell_pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

/* hw/rtl/uvs_checker.sv */
// Port-level checks for the UV sphere tessellator, bound to the top level.
// Depends on uv_sphere_tessellator_assert.svh.
`include "uv_sphere_tessellator_assert.svh"
module uvs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  `UVS_ASSERT_NEXT(a_reset_empty, !rst_n, !out_tvalid)
  `UVS_ASSERT_NEXT(a_reset_ready, !rst_n, in_tready)
  `UVS_ASSERT_RUN(a_pready, 1'b1, cfg_pready)
  `UVS_ASSERT_RUN(a_hold, $past(out_tvalid && !out_tready) && $past(rst_n), out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind uv_sphere_tessellator uvs_checker u_chk (.*);

/* bench/tb_uv_sphere_tessellator.sv */
// Testbench for the UV sphere tessellator: cells in, six checked vertices out.
// Depends on uvs_pkg and uv_sphere_tessellator; predicts each vertex locally.
`timescale 1ns / 100ps

module tb_uv_sphere_tessellator import uvs_pkg::*;;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic               last;
  } vertex_t;

  typedef struct {
    logic [7:0] si;
    logic [7:0] sj;
    logic       fixed;
    vertex_t    v0;
  } cell_row_t;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 40;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  uv_sphere_tessellator DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [15:0] radius_q, slice_q, stack_q;
  vertex_t     vertex_q[$];
  int          errors = 0;
  int          quiet = 0;
  int          stall_n = 0;
  bit          calm = 1'b0;

  function automatic longint fshr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // rotation-mode CORDIC, phase folded into the right half-plane
  function automatic void cordic_sincos(input logic [15:0] phase, output longint s,
                                        output longint c);
    longint ang, x, y, xs, ys;
    bit flip;
    ang = phase;
    flip = 1'b0;
    x = CORDIC_START;
    y = 0;
    if (ang >= 16384 && ang < 49152) begin
      ang -= 32768;
      flip = 1'b1;
    end else if (ang >= 49152) begin
      ang -= 65536;
    end
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      xs = fshr(x, k);
      ys = fshr(y, k);
      if (ang >= 0) begin
        x -= ys; y += xs; ang -= atan_turn(4'(k));
      end else begin
        x += ys; y -= xs; ang += atan_turn(4'(k));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = sat(y, SIN_LIMIT);
    c = sat(x, SIN_LIMIT);
  endfunction

  function automatic vertex_t corner_vertex(int p, int q, bit last);
    vertex_t v;
    longint sa, ca, sb, cb, rsb;
    logic [15:0] a, b;
    a = 16'((longint'(p) * slice_q) & 16'hFFFF);
    b = 16'((longint'(q) * stack_q) & 16'hFFFF);
    cordic_sincos(a, sa, ca);
    cordic_sincos(b, sb, cb);
    rsb = longint'(radius_q) * sb;
    v.x = 17'(sat(fshr(rsb * sa + (64'sd1 <<< 29), 30), POS_LIMIT));
    v.z = 17'(sat(fshr(rsb * ca + (64'sd1 <<< 29), 30), POS_LIMIT));
    v.y = 17'(sat(fshr(longint'(radius_q) * cb + (64'sd1 <<< 14), 15), POS_LIMIT));
    v.last = last;
    return v;
  endfunction

  task automatic predict_cell(input logic [7:0] i, input logic [7:0] j);
    for (int k = 0; k < 6; k++)
      vertex_q = {vertex_q, corner_vertex(int'(i) + CORNER_DI[k], int'(j) + CORNER_DJ[k],
                                          k == int'(LAST_VERTEX))};
  endtask

  // result side: stall bursts, compare each vertex against oldest prediction
  always @(posedge clk) begin
    vertex_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready || out_tvalid && out_tready) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got.x = out_tdata[16:0];
        got.y = out_tdata[33:17];
        got.z = out_tdata[50:34];
        got.last = out_tlast;
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex %h", $time, got);
          errors++;
        end else begin
          want = vertex_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z
              || got.last !== want.last) begin
            $display("%0t: vertex mismatch exp x=%0d y=%0d z=%0d last=%0d",
                     $time, want.x, want.y, want.z, want.last,
                     " act x=%0d y=%0d z=%0d last=%0d",
                     got.x, got.y, got.z, got.last);
            errors++;
          end
        end
      end
    end
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_n > 0) begin
      out_tready <= 1'b0;
      stall_n <= stall_n - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_n <= int'($urandom_range(0, 7));
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: radius_q = val[15:0];
      REG_SLICE:  slice_q = val[15:0];
      REG_STACK:  stack_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_cell(input logic [7:0] i, input logic [7:0] j);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {j, i};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cell(i, j);
  endtask

  cell_row_t dir_rows[$];

  initial begin
    cell_row_t r;
    radius_q = 16'd256; slice_q = 16'd4096; stack_q = 16'd4096;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // cell (0,0) after reset: north pole, y = radius
    r.si = 0; r.sj = 0; r.fixed = 1;
    r.v0.x = 0; r.v0.y = 17'sd256; r.v0.z = 0; r.v0.last = 0;
    dir_rows = {dir_rows, r};
    r.fixed = 0;
    r.si = 8'hFF; r.sj = 8'hFF; dir_rows = {dir_rows, r};
    r.si = 8'hFF; r.sj = 8'h00; dir_rows = {dir_rows, r};
    r.si = 8'h00; r.sj = 8'hFF; dir_rows = {dir_rows, r};
    r.si = 8'hAA; r.sj = 8'h55; dir_rows = {dir_rows, r};
    r.si = 8'h55; r.sj = 8'hAA; dir_rows = {dir_rows, r};
    r.si = 8'd3;  r.sj = 8'd4;  dir_rows = {dir_rows, r};
    foreach (dir_rows[k]) begin
      send_cell(dir_rows[k].si, dir_rows[k].sj);
      if (dir_rows[k].fixed && vertex_q[vertex_q.size() - 6] !== dir_rows[k].v0) begin
        $display("%0t: predictor disagrees with table exp %h act %h", $time,
                 dir_rows[k].v0, vertex_q[vertex_q.size() - 6]);
        errors++;
      end
    end
    in_tvalid <= 1'b0;
    wait_idle();
    // extremes of every register, including zero steps and the top bits
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_RADIUS, 32'hFFFF_FFFF); reg_write(REG_SLICE, 32'd1);
                 reg_write(REG_STACK, 32'd32768); end
        1: begin reg_write(REG_RADIUS, 32'd0); reg_write(REG_SLICE, 32'd0);
                 reg_write(REG_STACK, 32'd0); end
        2: begin reg_write(REG_RADIUS, 32'd256); reg_write(REG_SLICE, 32'hFFFF);
                 reg_write(REG_STACK, 32'h8001); reg_write(REG_UNUSED, 32'd77); end
        default: begin
          reg_write(REG_RADIUS, $urandom_range(0, 65535));
          reg_write(REG_SLICE, $urandom());
          reg_write(REG_STACK, $urandom_range(1, 32768));
        end
      endcase
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < 70; n++)
        send_cell(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      in_tvalid <= 1'b0;
      wait_idle();
    end
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_front.sv
hw/rtl/uvs_back.sv
hw/rtl/uv_sphere_tessellator.sv
hw/rtl/uvs_checker.sv
bench/tb_uv_sphere_tessellator.sv
